// File: src/cdq_pkg.sv
// ============================================================================
// cdq_pkg
// Shared types and constants for the circular deque: request and status
// codes, the cell command set and the sequencer states.
// ============================================================================
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 72;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH_FRONT = 3'd1,
        CELL_PUSH_BACK  = 3'd2,
        CELL_POP_FRONT  = 3'd3,
        CELL_POP_BACK   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    data;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WAIT = 1'b1
    } seq_state_t;

endpackage

// File: src/cdq_cell.sv
// ============================================================================
// cdq_cell
// One storage cell of the deque chain. It holds one word with its valid bit
// and one stage of the return lane that carries a word popped from the back
// toward the front of the chain.
// ============================================================================
module cdq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cdq_pkg::cell_ctrl_t ctrl,
    input  logic               left_vld,
    input  cdq_pkg::word_t     left_dat,
    input  logic               right_vld,
    input  cdq_pkg::word_t     right_dat,
    input  logic               right_rv,
    input  cdq_pkg::word_t     right_rd,
    output logic               vld,
    output cdq_pkg::word_t     dat,
    output logic               rv,
    output cdq_pkg::word_t     rd
);

    logic           vld_reg;
    logic           vld_next;
    cdq_pkg::word_t dat_reg;
    cdq_pkg::word_t dat_next;
    logic           rv_reg;
    logic           rv_next;
    cdq_pkg::word_t rd_reg;
    cdq_pkg::word_t rd_next;
    logic           is_last;
    logic           is_slot;

    assign is_last = vld_reg && !right_vld;
    assign is_slot = !vld_reg && left_vld;

    always_comb
    begin
        vld_next = vld_reg;
        dat_next = dat_reg;
        rv_next  = right_rv;
        rd_next  = right_rd;
        unique case (ctrl.op)
            cdq_pkg::CELL_PUSH_FRONT:
            begin
                vld_next = left_vld;
                dat_next = left_dat;
            end
            cdq_pkg::CELL_PUSH_BACK:
            begin
                if (is_slot)
                begin
                    vld_next = 1'b1;
                    dat_next = ctrl.data;
                end
            end
            cdq_pkg::CELL_POP_FRONT:
            begin
                vld_next = right_vld;
                dat_next = right_dat;
            end
            cdq_pkg::CELL_POP_BACK:
            begin
                if (is_last)
                begin
                    vld_next = 1'b0;
                    rv_next  = 1'b1;
                    rd_next  = dat_reg;
                end
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            rv_reg  <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_reg <= dat_next;
        rd_reg  <= rd_next;
    end

    assign vld = vld_reg;
    assign dat = dat_reg;
    assign rv  = rv_reg;
    assign rd  = rd_reg;

endmodule

// File: src/circular_deque.sv
// ============================================================================
// circular_deque
// Double-ended queue of DEPTH signed words built as a chain of cells.
// ============================================================================
// The deque lives in a row of DEPTH cells with the front word always in the
// first cell, so the front value, the empty flag and the full flag come from
// fixed places. Each request word is answered by one result word, and no new
// request is accepted until the result of the last one has been registered.
// A pop from the back waits until the popped word reaches the front of the
// chain, travelling one cell per cycle along the return lane. A stalled
// result port holds off the next acceptance.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] data_in
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] mode
    input  logic [cdq_pkg::MODE_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] data_out, [63:32] front_value, [64] is_empty, [65] is_full, rest zero
    output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [cdq_pkg::STATUS_W-1:0]  m_tuser
);

    cdq_pkg::seq_state_t state_reg;
    cdq_pkg::seq_state_t state_next;
    logic                pend_reg;
    logic                pend_next;
    cdq_pkg::word_t      pdata_reg;
    cdq_pkg::word_t      pdata_next;
    cdq_pkg::status_t    stat_reg;
    cdq_pkg::status_t    stat_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    cdq_pkg::word_t      dout_reg;
    cdq_pkg::word_t      dout_next;
    cdq_pkg::word_t      front_reg;
    cdq_pkg::word_t      front_next;
    logic                empty_reg;
    logic                empty_next;
    logic                full_reg;
    logic                full_next;
    cdq_pkg::status_t    ostat_reg;
    cdq_pkg::status_t    ostat_next;

    cdq_pkg::cell_ctrl_t ctrl;
    cdq_pkg::mode_t      mode;
    logic                out_free;
    logic                dq_empty;
    logic                dq_full;

    logic [DEPTH-1:0]    vld;
    logic [DEPTH-1:0]    rv;
    cdq_pkg::word_t      dat [DEPTH];
    cdq_pkg::word_t      rd  [DEPTH];

    assign mode     = cdq_pkg::mode_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;
    assign dq_empty = !vld[0];
    assign dq_full  = vld[DEPTH-1];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic           l_vld;
        cdq_pkg::word_t l_dat;
        logic           r_vld;
        cdq_pkg::word_t r_dat;
        logic           r_rv;
        cdq_pkg::word_t r_rd;

        if (i == 0)
        begin : g_first
            assign l_vld = 1'b1;
            assign l_dat = ctrl.data;
        end
        else
        begin : g_inner_l
            assign l_vld = vld[i-1];
            assign l_dat = dat[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_vld = 1'b0;
            assign r_dat = '0;
            assign r_rv  = 1'b0;
            assign r_rd  = '0;
        end
        else
        begin : g_inner_r
            assign r_vld = vld[i+1];
            assign r_dat = dat[i+1];
            assign r_rv  = rv[i+1];
            assign r_rd  = rd[i+1];
        end

        cdq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left_vld  (l_vld),
            .left_dat  (l_dat),
            .right_vld (r_vld),
            .right_dat (r_dat),
            .right_rv  (r_rv),
            .right_rd  (r_rd),
            .vld       (vld[i]),
            .dat       (dat[i]),
            .rv        (rv[i]),
            .rd        (rd[i])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        pdata_next    = pdata_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        dout_next     = dout_reg;
        front_next    = front_reg;
        empty_next    = empty_reg;
        full_next     = full_reg;
        ostat_next    = ostat_reg;
        ctrl.op       = cdq_pkg::CELL_HOLD;
        ctrl.data     = cdq_pkg::word_t'(s_tdata[cdq_pkg::WORD_W-1:0]);
        s_tready      = 1'b0;

        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = cdq_pkg::S_WAIT;
                    pend_next  = 1'b0;
                    pdata_next = '0;
                    stat_next  = cdq_pkg::STAT_DONE;
                    unique case (mode)
                        cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_BACK:
                        begin
                            if (dq_full)
                                stat_next = cdq_pkg::STAT_FULL;
                            else if (mode == cdq_pkg::MODE_PUSH_FRONT)
                                ctrl.op = cdq_pkg::CELL_PUSH_FRONT;
                            else
                                ctrl.op = cdq_pkg::CELL_PUSH_BACK;
                        end
                        cdq_pkg::MODE_POP_FRONT:
                        begin
                            if (dq_empty)
                                stat_next = cdq_pkg::STAT_EMPTY;
                            else
                            begin
                                ctrl.op    = cdq_pkg::CELL_POP_FRONT;
                                pdata_next = dat[0];
                            end
                        end
                        cdq_pkg::MODE_POP_BACK:
                        begin
                            if (dq_empty)
                                stat_next = cdq_pkg::STAT_EMPTY;
                            else
                            begin
                                ctrl.op   = cdq_pkg::CELL_POP_BACK;
                                pend_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            stat_next = cdq_pkg::STAT_DONE;
                        end
                    endcase
                end
            end
            cdq_pkg::S_WAIT:
            begin
                if (pend_reg)
                begin
                    if (rv[0])
                    begin
                        pend_next  = 1'b0;
                        pdata_next = rd[0];
                    end
                end
                else if (out_free)
                begin
                    state_next    = cdq_pkg::S_IDLE;
                    m_tvalid_next = 1'b1;
                    dout_next     = pdata_reg;
                    front_next    = vld[0] ? dat[0] : '0;
                    empty_next    = !vld[0];
                    full_next     = vld[DEPTH-1];
                    ostat_next    = stat_reg;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cdq_pkg::S_IDLE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pdata_reg <= pdata_next;
        stat_reg  <= stat_next;
        dout_reg  <= dout_next;
        front_reg <= front_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
        ostat_reg <= ostat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = ostat_reg;
    assign m_tdata  = {{(cdq_pkg::M_TDATA_W - 2 * cdq_pkg::WORD_W - 2){1'b0}},
                       full_reg, empty_reg, front_reg, dout_reg};

    // The occupied cells always form an unbroken run from the front.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld + DEPTH'(1)) & vld) == '0)
        else $error("occupied cells are not contiguous from the front");

    // A word on the return lane reaches the front only while a back pop waits for it.
    a_ret_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rv[0] |-> (state_reg == cdq_pkg::S_WAIT) && pend_reg)
        else $error("return lane delivered a word with no back pop pending");

    // At most one word travels on the return lane.
    a_ret_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rv))
        else $error("more than one word on the return lane");

    // A full deque is never reported empty.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && full_reg) |-> !empty_reg)
        else $error("result reports full and empty together");

    // A failed request pops nothing.
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (ostat_reg != cdq_pkg::STAT_DONE)) |-> (dout_reg == '0))
        else $error("rejected request returned data");

endmodule
